FILE: hdl/rdm_pkg.sv
`default_nettype none
package rdm_pkg;

  // Fixed frame bytes and bounds
  localparam logic [7:0] START_CODE    = 8'hCC;
  localparam logic [7:0] SUB_START     = 8'h01;
  localparam logic [7:0] HEADER_LEN    = 8'd24;
  localparam logic [7:0] MAX_DATA_LEN  = 8'd231;
  localparam logic [7:0] BYTE_ZERO     = 8'h00;
  localparam logic [7:0] BYTE_ONE      = 8'h01;

  // Emission steps of the back end: header bytes at 0..23, the data byte
  // of a data command at the last body step, then the two checksum bytes.
  localparam logic [4:0] STEP_FIRST    = 5'd0;
  localparam logic [4:0] STEP_BODY_END = 5'd23;
  localparam logic [4:0] STEP_SUM_HI   = 5'd24;
  localparam logic [4:0] STEP_SUM_LO   = 5'd25;

  // One classified command handed from the front end to the back end
  typedef struct packed {
    logic        is_data;
    logic        close;
    logic [47:0] dest_uid;
    logic [7:0]  command_class;
    logic [15:0] parameter_id;
    logic [7:0]  data_length;
    logic [7:0]  data_byte;
  } cmd_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

FILE: hdl/rdm_packet_framer_unit.sv
// RDM request framer.
// Input channel (in_valid/in_stall): a transaction with in_mode 0 is a header
// that opens a frame; in_mode 1 carries one parameter data byte. Data with no
// open frame is dropped. A header while a frame is open abandons that frame.
// Output channel (out_valid/out_stall): one frame byte per transaction;
// out_frame_end marks the low checksum byte.
// A front end classifies transactions and pushes commands into a short queue
// (QUEUE_DEPTH entries); a back end expands each command into bytes.
// An accepted command goes through the queue, the back end's current-command
// register and the output register. A header yields 24 bytes (26 with length
// zero), a data byte 1 byte (3 on the last one); the back end emits one byte
// per cycle while the receiver does not stall, so data transactions sustain
// one per cycle and headers are paced by the bytes they expand into.
// When the receiver stalls, the output register holds its byte and the queue
// fills; in_stall rises only when the queue is full.
// Reset (rst_n, synchronous) empties the queue, closes any frame and clears
// source_uid. The APB port holds source_uid at address 0.
`default_nettype none
module rdm_packet_framer_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         in_mode,
  input  wire  [47:0] in_dest_uid,
  input  wire  [7:0]  in_command_class,
  input  wire  [15:0] in_parameter_id,
  input  wire  [7:0]  in_data_length,
  input  wire  [7:0]  in_data_byte,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [7:0]  out_frame_byte,
  output logic        out_frame_end,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import rdm_pkg::*;

  localparam logic REG_SOURCE_UID = 1'b0;

  logic [47:0] source_uid_r, source_uid_nxt;
  logic        cfg_write;
  logic        push, pop;
  cmd_t        push_cmd, head_cmd;
  q_status_t   q_status;

  // Configuration register: written on the access phase of an APB write.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    source_uid_nxt = source_uid_r;
    if (cfg_write && (paddr[3] == REG_SOURCE_UID)) begin
      source_uid_nxt = pwdata[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_uid_r <= 48'd0;
    end else begin
      source_uid_r <= source_uid_nxt;
    end
  end

  assign prdata = (paddr[3] == REG_SOURCE_UID) ? {16'd0, source_uid_r} : 64'd0;

  rdm_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_dest_uid      (in_dest_uid),
    .in_command_class (in_command_class),
    .in_parameter_id  (in_parameter_id),
    .in_data_length   (in_data_length),
    .in_data_byte     (in_data_byte),
    .q_status         (q_status),
    .push             (push),
    .push_cmd         (push_cmd)
  );

  rdm_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_status (q_status)
  );

  rdm_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .source_uid     (source_uid_r),
    .head_cmd       (head_cmd),
    .q_status       (q_status),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_frame_end  (out_frame_end)
  );

endmodule
`default_nettype wire

FILE: hdl/rdm_front.sv
`default_nettype none
module rdm_front (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire               in_mode,
  input  wire  [47:0]       in_dest_uid,
  input  wire  [7:0]        in_command_class,
  input  wire  [15:0]       in_parameter_id,
  input  wire  [7:0]        in_data_length,
  input  wire  [7:0]        in_data_byte,
  input  rdm_pkg::q_status_t q_status,
  output logic              push,
  output rdm_pkg::cmd_t     push_cmd
);
  import rdm_pkg::*;

  logic       open_r, open_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] len_sat;
  logic       accept;

  // The input side is held off only while the queue is full.
  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;
  assign len_sat  = (in_data_length > MAX_DATA_LEN) ? MAX_DATA_LEN : in_data_length;

  // Classify the transaction and track the open packet.
  always_comb begin
    open_nxt               = open_r;
    left_nxt               = left_r;
    push                   = 1'b0;
    push_cmd.is_data       = in_mode;
    push_cmd.close         = 1'b0;
    push_cmd.dest_uid      = in_dest_uid;
    push_cmd.command_class = in_command_class;
    push_cmd.parameter_id  = in_parameter_id;
    push_cmd.data_length   = len_sat;
    push_cmd.data_byte     = in_data_byte;
    if (accept) begin
      if (!in_mode) begin
        // A header always opens a fresh packet, abandoning any open one.
        push           = 1'b1;
        push_cmd.close = (len_sat == 8'd0);
        open_nxt       = (len_sat != 8'd0);
        left_nxt       = len_sat;
      end else if (open_r) begin
        // The last expected data byte closes the frame with its checksum.
        push           = 1'b1;
        push_cmd.close = (left_r <= 8'd1);
        left_nxt       = (left_r != 8'd0) ? left_r - 8'd1 : left_r;
        open_nxt       = (left_r > 8'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      left_r <= 8'd0;
    end else begin
      open_r <= open_nxt;
      left_r <= left_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/rdm_cmd_queue.sv
`default_nettype none
module rdm_cmd_queue #(
  parameter int DEPTH = 4
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  rdm_pkg::cmd_t      push_cmd,
  input  wire                pop,
  output rdm_pkg::cmd_t      head_cmd,
  output rdm_pkg::q_status_t q_status
);
  import rdm_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t            store_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign q_status.full  = (count_r == FULL_CNT);
  assign q_status.empty = (count_r == '0);
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign head_cmd       = store_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Command storage carries no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Occupancy must never pass the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("command queue overfilled");

  // The front end must not offer a command while the queue is full.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_status.full))
    else $error("push into full command queue");

  // The back end must not take from an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && q_status.empty))
    else $error("pop from empty command queue");

endmodule
`default_nettype wire

FILE: hdl/rdm_back.sv
`default_nettype none
module rdm_back (
  input  wire                clk,
  input  wire                rst_n,
  input  wire  [47:0]        source_uid,
  input  rdm_pkg::cmd_t      head_cmd,
  input  rdm_pkg::q_status_t q_status,
  output logic               pop,
  output logic               out_valid,
  input  wire                out_stall,
  output logic [7:0]         out_frame_byte,
  output logic               out_frame_end
);
  import rdm_pkg::*;

  cmd_t        cur_r, cur_nxt;
  logic        cur_valid_r, cur_valid_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_end_r, out_end_nxt;
  logic        adv, finishing;
  logic [4:0]  last_step;
  logic [7:0]  cur_byte;

  assign adv       = !out_valid_r || !out_stall;
  assign last_step = cur_r.close ? STEP_SUM_LO : STEP_BODY_END;
  assign finishing = adv && cur_valid_r && (step_r == last_step);
  assign pop       = !q_status.empty && (!cur_valid_r || finishing);

  // Byte of the current command at the current step.
  always_comb begin
    case (step_r)
      STEP_FIRST:    cur_byte = START_CODE;
      5'd1:          cur_byte = SUB_START;
      5'd2:          cur_byte = HEADER_LEN + cur_r.data_length;
      5'd3:          cur_byte = cur_r.dest_uid[47:40];
      5'd4:          cur_byte = cur_r.dest_uid[39:32];
      5'd5:          cur_byte = cur_r.dest_uid[31:24];
      5'd6:          cur_byte = cur_r.dest_uid[23:16];
      5'd7:          cur_byte = cur_r.dest_uid[15:8];
      5'd8:          cur_byte = cur_r.dest_uid[7:0];
      5'd9:          cur_byte = source_uid[47:40];
      5'd10:         cur_byte = source_uid[39:32];
      5'd11:         cur_byte = source_uid[31:24];
      5'd12:         cur_byte = source_uid[23:16];
      5'd13:         cur_byte = source_uid[15:8];
      5'd14:         cur_byte = source_uid[7:0];
      5'd15:         cur_byte = BYTE_ZERO;
      5'd16:         cur_byte = BYTE_ONE;
      5'd17:         cur_byte = BYTE_ZERO;
      5'd18:         cur_byte = BYTE_ZERO;
      5'd19:         cur_byte = BYTE_ZERO;
      5'd20:         cur_byte = cur_r.command_class;
      5'd21:         cur_byte = cur_r.parameter_id[15:8];
      5'd22:         cur_byte = cur_r.parameter_id[7:0];
      STEP_BODY_END: cur_byte = cur_r.is_data ? cur_r.data_byte : cur_r.data_length;
      STEP_SUM_HI:   cur_byte = sum_r[15:8];
      STEP_SUM_LO:   cur_byte = sum_r[7:0];
      default:       cur_byte = BYTE_ZERO;
    endcase
  end

  // Sequencer: step through the current command, one byte per free output slot.
  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    step_nxt      = step_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_end_nxt   = out_end_r;

    if (adv) begin
      out_valid_nxt = cur_valid_r;
      out_byte_nxt  = cur_byte;
      out_end_nxt   = (step_r == STEP_SUM_LO);
    end

    if (adv && cur_valid_r) begin
      // A header restarts the sum; checksum bytes are not summed.
      if (step_r == STEP_FIRST) begin
        sum_nxt = {8'd0, cur_byte};
      end else if (step_r <= STEP_BODY_END) begin
        sum_nxt = sum_r + {8'd0, cur_byte};
      end
      step_nxt = step_r + 5'd1;
      if (finishing) begin
        cur_valid_nxt = 1'b0;
      end
    end

    if (pop) begin
      cur_nxt       = head_cmd;
      cur_valid_nxt = 1'b1;
      step_nxt      = head_cmd.is_data ? STEP_BODY_END : STEP_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      step_r      <= STEP_FIRST;
      sum_r       <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      step_r      <= step_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_byte_r <= out_byte_nxt;
    out_end_r  <= out_end_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_frame_end  = out_end_r;

  // An active command never runs past the low checksum byte.
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (step_r <= STEP_SUM_LO))
    else $error("emission step out of range");

  // A byte taken from the low checksum step always carries the end flag.
  a_end_source: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && cur_valid_r && (step_r == STEP_SUM_LO)) |=> (out_valid && out_frame_end))
    else $error("frame end flag lost");

endmodule
`default_nettype wire
